>>> sv/slcf_pkg.sv
// Shared types, constants and the CRC byte update for the sync/length/CRC framer.
// No dependencies; every other file but slcf_checker imports this package.
package slcf_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 4;
    localparam int CFG_INDEX_W = 8;

    localparam logic [15:0] SYNC_WORD_RESET   = 16'hAA55;
    localparam logic [15:0] CRC_INITIAL_RESET = 16'hFFFF;
    localparam logic [15:0] CRC_POLY_RESET    = 16'h1021;
    localparam logic [15:0] CRC_MASK_RESET    = 16'h8000;

    localparam logic [CFG_INDEX_W-1:0] REG_SYNC_WORD      = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CRC_INITIAL    = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CRC_POLYNOMIAL = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CRC_TEST_MASK  = 8'd3;

    typedef struct packed {
        logic        start;
        logic        has_data;
        logic        append_crc;
        logic [15:0] length;
        logic [7:0]  data;
    } cmd_t;

    typedef struct packed {
        logic [15:0] sync_word;
        logic [15:0] crc_initial;
        logic [15:0] crc_polynomial;
        logic [15:0] crc_test_mask;
    } cfg_t;

    typedef enum logic [2:0] {
        PH_HEAD,
        PH_SYNC_HI,
        PH_SYNC_LO,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_DATA,
        PH_CRC_HI,
        PH_CRC_LO
    } phase_t;

    function automatic logic [15:0] crc_update(
        input logic [15:0] crc_in,
        input logic [7:0]  b,
        input logic [15:0] poly,
        input logic [15:0] mask
    );
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if ((c & mask) != 16'h0000)
                c = {c[14:0], 1'b0} ^ poly;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

>>> sv/sync_length_crc_framer.sv
// Sync/length/CRC framer top level: configuration registers, front end, queue, back end.
// Depends on slcf_pkg, slcf_front, slcf_queue, slcf_back.
//
// Each frame goes out as two sync bytes, a big-endian 16-bit length, the payload and a
// big-endian CRC-16 (MSB first, over sync, length and payload). A start word emits the
// four header bytes, its payload byte if the length is nonzero, then the CRC if the frame
// is done; a data word emits one byte, plus the CRC after the last one; a data word
// outside a frame is dropped. The input takes one word per cycle while the command queue
// (QUEUE_DEPTH entries) has room; the output sends one byte per cycle while out_ready
// is high. Registers are written with cfg_valid (always ready) and are meant to change
// only while no frame is in flight.
module sync_length_crc_framer #(
    parameter int QUEUE_DEPTH = slcf_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             frame_start,
    input  logic [15:0]                      frame_length,
    input  logic [7:0]                       data_byte,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [7:0]                       out_byte,
    output logic                             run_last,
    output logic                             frame_end,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [slcf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [15:0]                      cfg_data
);
    import slcf_pkg::*;

    cfg_t cfg_reg;
    cmd_t push_cmd, head_cmd;
    logic push, pop, queue_full, head_valid;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_word      <= SYNC_WORD_RESET;
            cfg_reg.crc_initial    <= CRC_INITIAL_RESET;
            cfg_reg.crc_polynomial <= CRC_POLY_RESET;
            cfg_reg.crc_test_mask  <= CRC_MASK_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SYNC_WORD:      cfg_reg.sync_word      <= cfg_data;
                REG_CRC_INITIAL:    cfg_reg.crc_initial    <= cfg_data;
                REG_CRC_POLYNOMIAL: cfg_reg.crc_polynomial <= cfg_data;
                REG_CRC_TEST_MASK:  cfg_reg.crc_test_mask  <= cfg_data;
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    slcf_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .frame_start  (frame_start),
        .frame_length (frame_length),
        .data_byte    (data_byte),
        .queue_full   (queue_full),
        .push         (push),
        .push_cmd     (push_cmd)
    );

    slcf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    slcf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .run_last   (run_last),
        .frame_end  (frame_end)
    );

endmodule

>>> sv/slcf_front.sv
// Front end: accepts input words, tracks frame position and builds expansion commands.
// Depends on slcf_pkg.
module slcf_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic            frame_start,
    input  logic [15:0]     frame_length,
    input  logic [7:0]      data_byte,
    input  logic            queue_full,
    output logic            push,
    output slcf_pkg::cmd_t  push_cmd
);
    import slcf_pkg::*;

    logic [15:0] remaining_reg, remaining_next;
    logic        in_frame_reg, in_frame_next;
    logic        accept;
    logic [15:0] len_dec;
    logic [15:0] rem_dec;
    logic        has_data;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;
    assign len_dec  = frame_length - 16'd1;
    assign rem_dec  = (remaining_reg != 16'd0) ? remaining_reg - 16'd1 : 16'd0;
    assign has_data = frame_length != 16'd0;

    always_comb
    begin
        remaining_next      = remaining_reg;
        in_frame_next       = in_frame_reg;
        push                = 1'b0;
        push_cmd.start      = frame_start;
        push_cmd.has_data   = 1'b1;
        push_cmd.append_crc = 1'b0;
        push_cmd.length     = frame_length;
        push_cmd.data       = data_byte;
        if (accept && frame_start)
        begin
            push                = 1'b1;
            push_cmd.has_data   = has_data;
            push_cmd.append_crc = !has_data || (len_dec == 16'd0);
            remaining_next      = has_data ? len_dec : 16'd0;
            in_frame_next       = !push_cmd.append_crc;
        end
        else if (accept && in_frame_reg)
        begin
            push                = 1'b1;
            push_cmd.append_crc = rem_dec == 16'd0;
            remaining_next      = rem_dec;
            in_frame_next       = rem_dec != 16'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remaining_reg <= 16'd0;
            in_frame_reg  <= 1'b0;
        end
        else
        begin
            remaining_reg <= remaining_next;
            in_frame_reg  <= in_frame_next;
        end
    end

endmodule

>>> sv/slcf_queue.sv
// Short command queue between front and back end.
// Depends on slcf_pkg.
module slcf_queue #(
    parameter int DEPTH = slcf_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  slcf_pkg::cmd_t  push_cmd,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output slcf_pkg::cmd_t  head_cmd
);
    import slcf_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = PTR_W + 1;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full       = count_reg == DEPTH_CNT;
    assign head_valid = count_reg != '0;
    assign head_cmd   = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> sv/slcf_back.sv
// Back end: expands commands into framed bytes, runs the CRC and holds the output word.
// Depends on slcf_pkg.
module slcf_back (
    input  logic            clk,
    input  logic            rst_n,
    input  slcf_pkg::cfg_t  cfg,
    input  logic            head_valid,
    input  slcf_pkg::cmd_t  head_cmd,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      out_byte,
    output logic            run_last,
    output logic            frame_end
);
    import slcf_pkg::*;

    phase_t      phase_reg, phase_next, cur_phase;
    logic [15:0] crc_reg, crc_next;
    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic        run_last_reg;
    logic        frame_end_reg;
    logic        advance;
    logic [7:0]  emit_byte;
    logic        emit_feed;
    logic        emit_done;
    logic        emit_end;
    logic [15:0] crc_base;

    assign advance   = head_valid && (!out_valid_reg || out_ready);
    assign cur_phase = (phase_reg == PH_HEAD) ? (head_cmd.start ? PH_SYNC_HI : PH_DATA)
                                              : phase_reg;

    always_comb
    begin
        phase_next = phase_reg;
        if (advance)
        begin
            case (cur_phase)
                PH_SYNC_HI: phase_next = PH_SYNC_LO;
                PH_SYNC_LO: phase_next = PH_LEN_HI;
                PH_LEN_HI:  phase_next = PH_LEN_LO;
                PH_LEN_LO:  phase_next = head_cmd.has_data ? PH_DATA : PH_CRC_HI;
                PH_DATA:    phase_next = head_cmd.append_crc ? PH_CRC_HI : PH_HEAD;
                PH_CRC_HI:  phase_next = PH_CRC_LO;
                PH_CRC_LO:  phase_next = PH_HEAD;
                default:    phase_next = PH_HEAD;
            endcase
        end
    end

    always_comb
    begin
        emit_byte = 8'h00;
        emit_feed = 1'b0;
        emit_done = 1'b0;
        emit_end  = 1'b0;
        case (cur_phase)
            PH_SYNC_HI:
            begin
                emit_byte = cfg.sync_word[15:8];
                emit_feed = 1'b1;
            end
            PH_SYNC_LO:
            begin
                emit_byte = cfg.sync_word[7:0];
                emit_feed = 1'b1;
            end
            PH_LEN_HI:
            begin
                emit_byte = head_cmd.length[15:8];
                emit_feed = 1'b1;
            end
            PH_LEN_LO:
            begin
                emit_byte = head_cmd.length[7:0];
                emit_feed = 1'b1;
            end
            PH_DATA:
            begin
                emit_byte = head_cmd.data;
                emit_feed = 1'b1;
                emit_done = !head_cmd.append_crc;
            end
            PH_CRC_HI:
            begin
                emit_byte = crc_reg[15:8];
            end
            PH_CRC_LO:
            begin
                emit_byte = crc_reg[7:0];
                emit_done = 1'b1;
                emit_end  = 1'b1;
            end
            default:
            begin
                emit_byte = 8'h00;
            end
        endcase
    end

    // restart the CRC on the first sync byte
    assign crc_base = (cur_phase == PH_SYNC_HI) ? cfg.crc_initial : crc_reg;
    assign crc_next = (advance && emit_feed)
                    ? crc_update(crc_base, emit_byte, cfg.crc_polynomial, cfg.crc_test_mask)
                    : crc_reg;
    assign pop      = advance && emit_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEAD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        crc_reg <= crc_next;
        if (advance)
        begin
            out_byte_reg  <= emit_byte;
            run_last_reg  <= emit_done;
            frame_end_reg <= emit_end;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign run_last  = run_last_reg;
    assign frame_end = frame_end_reg;

endmodule

>>> sv/slcf_checker.sv
// Port-level checks for the framer output stream, bound to the top level.
// Does not depend on slcf_pkg; it sees the bound top level ports only.
module slcf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       run_last,
    input logic       frame_end
);

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte)
            && $stable(run_last) && $stable(frame_end))
        else $error("stalled output word changed");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_end |-> run_last)
        else $error("frame end without run end");

    a_no_double_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && frame_end |=> !(out_valid && frame_end))
        else $error("two frame ends in a row");

endmodule

bind sync_length_crc_framer slcf_checker u_slcf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .run_last  (run_last),
    .frame_end (frame_end)
);

>>> verif/sync_length_crc_framer_checker.sv
// Scoreboard for the sync/length/CRC framer: predicts the framed byte stream from the
// input, config and reset traffic, and compares every output word against it.
// Depends on slcf_pkg for register indexes, reset values and the config index width.
module sync_length_crc_framer_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_ready,
    input  logic                             frame_start,
    input  logic [15:0]                      frame_length,
    input  logic [7:0]                       data_byte,
    input  logic                             out_valid,
    input  logic                             out_ready,
    input  logic [7:0]                       out_byte,
    input  logic                             run_last,
    input  logic                             frame_end,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [slcf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [15:0]                      cfg_data,
    output int                               mismatches,
    output int                               bytes_owed
);
    import slcf_pkg::*;

    typedef struct packed {
        logic [7:0] value;
        logic       word_last;
        logic       frame_last;
    } framed_byte_t;

    framed_byte_t owed_q[$];
    framed_byte_t staged;
    logic         have_staged;

    logic [15:0] sync_reg;
    logic [15:0] crc_init_reg;
    logic [15:0] crc_poly_reg;
    logic [15:0] crc_mask_reg;

    logic [15:0] running_crc;
    logic [15:0] payload_left;
    logic        framing;
    int          err_total = 0;

    function automatic logic [15:0] crc_shift_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] r;
        r = crc ^ {b, 8'h00};
        repeat (8)
        begin
            if ((r & crc_mask_reg) != 16'h0000)
                r = (r << 1) ^ crc_poly_reg;
            else
                r = r << 1;
        end
        return r;
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic frame_last);
        if (have_staged)
            owed_q = {owed_q, staged};
        staged.value      = b;
        staged.word_last  = 1'b0;
        staged.frame_last = frame_last;
        have_staged       = 1'b1;
    endtask

    task automatic emit_framed(input logic [7:0] b);
        running_crc = crc_shift_byte(running_crc, b);
        push_byte(b, 1'b0);
    endtask

    task automatic emit_crc();
        push_byte(running_crc[15:8], 1'b0);
        push_byte(running_crc[7:0], 1'b1);
        framing      = 1'b0;
        payload_left = 16'd0;
    endtask

    task automatic predict_word(input logic s, input logic [15:0] len, input logic [7:0] d);
        if (s)
        begin
            running_crc = crc_init_reg;
            framing     = 1'b1;
            emit_framed(sync_reg[15:8]);
            emit_framed(sync_reg[7:0]);
            emit_framed(len[15:8]);
            emit_framed(len[7:0]);
            if (len == 16'd0)
                emit_crc();
            else
            begin
                emit_framed(d);
                payload_left = len - 16'd1;
                if (payload_left == 16'd0)
                    emit_crc();
            end
        end
        else if (framing)
        begin
            emit_framed(d);
            if (payload_left != 16'd0)
                payload_left = payload_left - 16'd1;
            if (payload_left == 16'd0)
                emit_crc();
        end
        // mark the final byte of this word
        if (have_staged)
        begin
            staged.word_last = 1'b1;
            owed_q = {owed_q, staged};
            have_staged = 1'b0;
        end
    endtask

    task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t %s mismatch: expected %0h, actual %0h", $time, what, want, got);
            err_total++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        framed_byte_t want;
        if (!rst_n)
        begin
            sync_reg     = SYNC_WORD_RESET;
            crc_init_reg = CRC_INITIAL_RESET;
            crc_poly_reg = CRC_POLY_RESET;
            crc_mask_reg = CRC_MASK_RESET;
            running_crc  = 16'd0;
            payload_left = 16'd0;
            framing      = 1'b0;
            have_staged  = 1'b0;
            owed_q.delete();
            bytes_owed <= 0;
            mismatches <= err_total;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_SYNC_WORD:      sync_reg     = cfg_data;
                    REG_CRC_INITIAL:    crc_init_reg = cfg_data;
                    REG_CRC_POLYNOMIAL: crc_poly_reg = cfg_data;
                    REG_CRC_TEST_MASK:  crc_mask_reg = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                predict_word(frame_start, frame_length, data_byte);
            if (out_valid && out_ready)
            begin
                if (owed_q.size() == 0)
                begin
                    $display("%0t out_byte mismatch: expected none, actual %0h",
                             $time, out_byte);
                    err_total++;
                end
                else
                begin
                    want = owed_q.pop_front();
                    check_field("out_byte", want.value, out_byte);
                    check_field("run_last", {7'd0, want.word_last}, {7'd0, run_last});
                    check_field("frame_end", {7'd0, want.frame_last}, {7'd0, frame_end});
                end
            end
            bytes_owed <= owed_q.size();
            mismatches <= err_total;
        end
    end

endmodule

>>> verif/sync_length_crc_framer_tb.sv
// Top of the framer regression: clock, reset, config writes, word stimulus and output
// backpressure; the verdict comes from sync_length_crc_framer_checker.
// Depends on slcf_pkg, sync_length_crc_framer and sync_length_crc_framer_checker.
module sync_length_crc_framer_tb;
    import slcf_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 2 * QUEUE_DEPTH_DEFAULT + 16;
    localparam int PHASE_WORDS  = 12;

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   in_valid     = 1'b0;
    logic                   in_ready;
    logic                   frame_start  = 1'b0;
    logic [15:0]            frame_length = 16'd0;
    logic [7:0]             data_byte    = 8'd0;
    logic                   out_valid;
    logic                   out_ready    = 1'b0;
    logic [7:0]             out_byte;
    logic                   run_last;
    logic                   frame_end;
    logic                   cfg_valid    = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [15:0]            cfg_data     = 16'd0;

    int   mismatches;
    int   bytes_owed;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    logic hold_go       = 1'b0;
    int   cycle_count   = 0;

    sync_length_crc_framer i_dut (.*);

    sync_length_crc_framer_checker i_checker (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("sync_length_crc_framer regression: fail");
            $finish;
        end
    end

    initial
    begin
        int held;
        held = 0;
        forever
        begin
            @(posedge clk);
            if (!rst_n)
                out_ready <= 1'b0;
            else if (hold_go && held < HOLD_CYCLES)
            begin
                out_ready <= 1'b0;
                held++;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_word(input logic s, input logic [15:0] len, input logic [7:0] d);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        frame_start  <= s;
        frame_length <= len;
        data_byte    <= d;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic settle_down();
        in_valid <= 1'b0;
        @(posedge clk);
        while (bytes_owed != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic program_regs(input logic [15:0] sync, input logic [15:0] init,
                                input logic [15:0] poly, input logic [15:0] mask,
                                input logic [CFG_INDEX_W-1:0] stray_index);
        cfg_write(stray_index, 16'($urandom));
        cfg_write(REG_SYNC_WORD, sync);
        cfg_write(REG_CRC_INITIAL, init);
        cfg_write(REG_CRC_POLYNOMIAL, poly);
        cfg_write(REG_CRC_TEST_MASK, mask);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_frame(inout int words);
        int pick;
        int len;
        int body;
        pick = $urandom_range(99);
        if (pick < 8)
            send_word(1'b0, 16'($urandom), 8'($urandom));
        else if (pick < 16)
        begin
            // open a long frame and abandon it after at most three more data words
            len  = $urandom_range(5, 65535);
            body = $urandom_range(0, 3);
            send_word(1'b1, 16'(len), 8'($urandom));
            repeat (body) send_word(1'b0, 16'($urandom), 8'($urandom));
            words += 1 + body;
        end
        else
        begin
            if (pick < 32)
                len = 0;
            else if (pick < 90)
                len = $urandom_range(1, 8);
            else
                len = $urandom_range(9, 40);
            send_word(1'b1, 16'(len), 8'($urandom));
            for (int i = 1; i < len; i++)
                send_word(1'b0, 16'($urandom), 8'($urandom));
            words += (len > 0) ? len : 1;
        end
    endtask

    initial
    begin
        int words;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct <= 7;
        recv_idle_pct <= 54;
        program_regs(SYNC_WORD_RESET, CRC_INITIAL_RESET, CRC_POLY_RESET, CRC_MASK_RESET,
                     8'hFF);

        send_word(1'b1, 16'h0000, 8'hA5);
        send_word(1'b0, 16'h1234, 8'h00);
        send_word(1'b1, 16'h0001, 8'hFF);
        send_word(1'b1, 16'hFFFF, 8'h00);
        send_word(1'b0, 16'h0000, 8'hFF);
        send_word(1'b0, 16'hFFFF, 8'h80);
        send_word(1'b1, 16'h0003, 8'h01);
        send_word(1'b0, 16'h0000, 8'h7F);
        send_word(1'b0, 16'h0000, 8'hFE);
        send_word(1'b1, 16'h8000, 8'h55);
        send_word(1'b1, 16'h0002, 8'hAA);
        send_word(1'b0, 16'h5555, 8'h0F);
        send_word(1'b1, 16'h00FF, 8'hF0);
        send_word(1'b1, 16'h0000, 8'h00);
        send_word(1'b0, 16'hAAAA, 8'h3C);
        settle_down();

        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: program_regs(16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                CFG_INDEX_W'($urandom_range(4, 255)));
                1:
                begin
                    program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                 CFG_INDEX_W'($urandom_range(4, 255)));
                    hold_go <= 1'b1;
                end
                2, 3:
                begin
                    send_idle_pct <= 54;
                    recv_idle_pct <= 7;
                    program_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                                 CFG_INDEX_W'($urandom_range(4, 255)));
                end
                default:
                begin
                    send_idle_pct <= 0;
                    recv_idle_pct <= 0;
                    program_regs(SYNC_WORD_RESET, CRC_INITIAL_RESET, CRC_POLY_RESET,
                                 CRC_MASK_RESET, CFG_INDEX_W'($urandom_range(4, 255)));
                end
            endcase
            words = 0;
            while (words < PHASE_WORDS)
                random_frame(words);
            settle_down();
        end

        if (mismatches == 0)
            $display("sync_length_crc_framer regression: pass");
        else
            $display("sync_length_crc_framer regression: fail");
        $finish;
    end

endmodule
